>>> sv/apq_pkg.sv
// Shared constants, types and the ranking function of the array priority queue.
package apq_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int VAL_W       = 32;
  localparam int PRI_W       = 16;
  localparam int ENTRY_W     = VAL_W + PRI_W;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_FIN
  } state_t;

  // One entry offered to, or held by, the best-entry tracker.
  typedef struct packed {
    logic                     valid;
    logic signed [VAL_W-1:0]  value;
    logic signed [PRI_W-1:0]  prio;
    logic [ADDR_W-1:0]        pos;
  } cand_t;

  // True when entry a is served before entry b that sits at an earlier position.
  function automatic logic outranks(input logic signed [PRI_W-1:0] a_prio,
                                    input logic signed [VAL_W-1:0] a_value,
                                    input logic signed [PRI_W-1:0] b_prio,
                                    input logic signed [VAL_W-1:0] b_value);
    return (a_prio > b_prio) || ((a_prio == b_prio) && (a_value > b_value));
  endfunction

endpackage

>>> sv/array_priority_queue_unit.sv
// Top level of the array priority queue: sequencer, head registers and result words.
//
// A command word (operation, entry_value, entry_priority) is taken at a rising
// edge where start is high and busy is low. Every command gives exactly one
// result word, shown on the result ports for one cycle while done is high; the
// receiver cannot stall it and must take it then.
// An enqueue, a dequeue on an empty queue and a dequeue that empties the queue
// finish without a pass over the store: done rises in the cycle after start, busy stays low.
// Any other dequeue runs one pass over the store, which sits in a single RAM
// with one write and one read port: one read per cycle over the n + 1 entries
// held before the dequeue, then the read pipeline drains and the new head is
// loaded, and done follows. During that pass each entry behind the removed
// one is moved down one place and the best remaining entry is tracked, so no
// separate shift pass is needed.
// The head (best entry) is held in registers and updated on enqueue and at the end of a dequeue pass.
// Synchronous reset empties the queue; the RAM contents are not cleared and
// are never read below the held count before being written.
module array_priority_queue_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 operation,
  input  logic signed [apq_pkg::VAL_W-1:0]     entry_value,
  input  logic signed [apq_pkg::PRI_W-1:0]     entry_priority,
  output logic                                 done,
  output logic [1:0]                           status,
  output logic signed [apq_pkg::VAL_W-1:0]     taken_value,
  output logic signed [apq_pkg::PRI_W-1:0]     taken_priority,
  output logic                                 head_valid,
  output logic signed [apq_pkg::VAL_W-1:0]     head_value,
  output logic signed [apq_pkg::PRI_W-1:0]     head_priority,
  output logic [apq_pkg::CNT_W-1:0]            entry_count
);
  import apq_pkg::*;

  // Control state.
  state_t                   state, state_next;
  logic [CNT_W-1:0]         count, count_next;
  logic [ADDR_W-1:0]        ptr, ptr_next;
  logic                     rd_pend, rd_pend_next;
  logic [ADDR_W-1:0]        rd_idx, rd_idx_next;
  logic                     res_done, res_done_next;

  // Head of the queue.
  logic signed [VAL_W-1:0]  head_val, head_val_next;
  logic signed [PRI_W-1:0]  head_pri, head_pri_next;
  logic [ADDR_W-1:0]        head_pos, head_pos_next;

  // Result word registers.
  status_t                  res_status, res_status_next;
  logic signed [VAL_W-1:0]  res_taken_val, res_taken_val_next;
  logic signed [PRI_W-1:0]  res_taken_pri, res_taken_pri_next;
  logic                     res_head_ok, res_head_ok_next;
  logic signed [VAL_W-1:0]  res_head_val, res_head_val_next;
  logic signed [PRI_W-1:0]  res_head_pri, res_head_pri_next;
  logic [CNT_W-1:0]         res_count, res_count_next;

  // Memory and tracker connections.
  logic                     ram_we, ram_re;
  logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]       ram_wdata, ram_rdata;
  logic                     best_clear;
  cand_t                    cand, best;
  logic                     accept;

  assign accept = start && (state == ST_IDLE);

  apq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  apq_best u_best (
    .clk   (clk),
    .rst   (rst),
    .clear (best_clear),
    .cand  (cand),
    .best  (best)
  );

  // Sequencer: next state, store accesses and result word.
  always_comb begin
    state_next         = state;
    count_next         = count;
    ptr_next           = ptr;
    rd_pend_next       = 1'b0;
    rd_idx_next        = rd_idx;
    res_done_next      = 1'b0;
    head_val_next      = head_val;
    head_pri_next      = head_pri;
    head_pos_next      = head_pos;
    res_status_next    = res_status;
    res_taken_val_next = res_taken_val;
    res_taken_pri_next = res_taken_pri;
    res_head_ok_next   = res_head_ok;
    res_head_val_next  = res_head_val;
    res_head_pri_next  = res_head_pri;
    res_count_next     = res_count;
    ram_we             = 1'b0;
    ram_waddr          = rd_idx - ADDR_W'(1);
    ram_wdata          = ram_rdata;
    ram_re             = 1'b0;
    ram_raddr          = ptr;
    best_clear         = 1'b0;
    cand.valid         = 1'b0;
    cand.value         = ram_rdata[VAL_W-1:0];
    cand.prio          = ram_rdata[ENTRY_W-1:VAL_W];
    cand.pos           = rd_idx;

    // Returning read data: entries before the removed one stay, later ones move down.
    if (rd_pend) begin
      if (rd_idx < head_pos) begin
        cand.valid = 1'b1;
      end else if (rd_idx > head_pos) begin
        cand.valid = 1'b1;
        cand.pos   = rd_idx - ADDR_W'(1);
        ram_we     = 1'b1;
      end
    end

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          res_done_next      = 1'b1;
          res_taken_val_next = '0;
          res_taken_pri_next = '0;
          if (operation == OP_ENQUEUE) begin
            if (count == CNT_W'(QUEUE_DEPTH)) begin
              res_status_next = STATUS_FULL;
            end else begin
              res_status_next = STATUS_DONE;
              ram_we          = 1'b1;
              ram_waddr       = count[ADDR_W-1:0];
              ram_wdata       = {entry_priority, entry_value};
              count_next      = count + CNT_W'(1);
              if ((count == '0) ||
                  outranks(entry_priority, entry_value, head_pri, head_val)) begin
                head_val_next = entry_value;
                head_pri_next = entry_priority;
                head_pos_next = count[ADDR_W-1:0];
              end
            end
            res_head_ok_next  = 1'b1;
            res_head_val_next = head_val_next;
            res_head_pri_next = head_pri_next;
            res_count_next    = count_next;
          end else if (count == '0) begin
            res_status_next   = STATUS_EMPTY;
            res_head_ok_next  = 1'b0;
            res_head_val_next = '0;
            res_head_pri_next = '0;
            res_count_next    = '0;
          end else begin
            res_status_next    = STATUS_DONE;
            res_taken_val_next = head_val;
            res_taken_pri_next = head_pri;
            count_next         = count - CNT_W'(1);
            if (count == CNT_W'(1)) begin
              res_head_ok_next  = 1'b0;
              res_head_val_next = '0;
              res_head_pri_next = '0;
              res_count_next    = '0;
            end else begin
              // Hold the word back until the pass over the store is done.
              res_done_next = 1'b0;
              best_clear    = 1'b1;
              ptr_next      = '0;
              state_next    = ST_SCAN;
            end
          end
        end
      end

      ST_SCAN: begin
        // Read one entry a cycle over the old positions, up to the new count.
        ram_re       = 1'b1;
        rd_pend_next = 1'b1;
        rd_idx_next  = ptr;
        ptr_next     = ptr + ADDR_W'(1);
        if (ptr == count[ADDR_W-1:0]) begin
          state_next = ST_LAST;
        end
      end

      ST_LAST: begin
        state_next = ST_FIN;
      end

      ST_FIN: begin
        head_val_next     = best.value;
        head_pri_next     = best.prio;
        head_pos_next     = best.pos;
        res_head_ok_next  = 1'b1;
        res_head_val_next = best.value;
        res_head_pri_next = best.prio;
        res_count_next    = count;
        res_done_next     = 1'b1;
        state_next        = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      rd_pend  <= 1'b0;
      res_done <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      rd_pend  <= rd_pend_next;
      res_done <= res_done_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ptr           <= ptr_next;
    rd_idx        <= rd_idx_next;
    head_val      <= head_val_next;
    head_pri      <= head_pri_next;
    head_pos      <= head_pos_next;
    res_status    <= res_status_next;
    res_taken_val <= res_taken_val_next;
    res_taken_pri <= res_taken_pri_next;
    res_head_ok   <= res_head_ok_next;
    res_head_val  <= res_head_val_next;
    res_head_pri  <= res_head_pri_next;
    res_count     <= res_count_next;
  end

  // Ports.
  assign busy           = (state != ST_IDLE);
  assign done           = res_done;
  assign status         = res_status;
  assign taken_value    = res_taken_val;
  assign taken_priority = res_taken_pri;
  assign head_valid     = res_head_ok;
  assign head_value     = res_head_val;
  assign head_priority  = res_head_pri;
  assign entry_count    = res_count;

endmodule

>>> sv/apq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module apq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/apq_best.sv
// Tracker that keeps the best entry seen during a scan of the store.
module apq_best (
  input  logic           clk,
  input  logic           rst,
  input  logic           clear,
  input  apq_pkg::cand_t cand,
  output apq_pkg::cand_t best
);
  import apq_pkg::*;

  cand_t held;

  // Candidates arrive in position order, so a strict win keeps the earliest on a full tie.
  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid <= 1'b0;
    end else if (clear) begin
      held.valid <= 1'b0;
    end else if (cand.valid) begin
      if (!held.valid || outranks(cand.prio, cand.value, held.prio, held.value)) begin
        held <= cand;
      end
    end
  end

  assign best = held;

endmodule

>>> dv/tb_top.sv
// Self-checking testbench of the array priority queue: directed table, then random command words.
module tb_top;
  import apq_pkg::*;

  localparam int RANDOM_WORDS   = 750;
  localparam int CALM_WORDS     = 75;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 140;

  // One result word as the block shows it while done is high.
  typedef struct packed {
    status_t                  status;
    logic signed [VAL_W-1:0]  taken_value;
    logic signed [PRI_W-1:0]  taken_priority;
    logic                     head_valid;
    logic signed [VAL_W-1:0]  head_value;
    logic signed [PRI_W-1:0]  head_priority;
    logic [CNT_W-1:0]         entry_count;
  } result_word_t;

  // One row of the directed table; typed rows carry their result word.
  typedef struct {
    op_t                      op;
    logic signed [VAL_W-1:0]  value;
    logic signed [PRI_W-1:0]  prio;
    bit                       typed;
    result_word_t             word;
  } plan_row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     busy;
  logic                     operation = 1'b0;
  logic signed [VAL_W-1:0]  entry_value = '0;
  logic signed [PRI_W-1:0]  entry_priority = '0;
  logic                     done;
  logic [1:0]               status;
  logic signed [VAL_W-1:0]  taken_value;
  logic signed [PRI_W-1:0]  taken_priority;
  logic                     head_valid;
  logic signed [VAL_W-1:0]  head_value;
  logic signed [PRI_W-1:0]  head_priority;
  logic [CNT_W-1:0]         entry_count;

  // Shadow copy of the queue contents, in arrival order.
  logic signed [VAL_W-1:0]  shadow_value [QUEUE_DEPTH];
  logic signed [PRI_W-1:0]  shadow_prio  [QUEUE_DEPTH];
  int                       shadow_len = 0;

  result_word_t             words_due [$];
  plan_row_t                plan [$];
  int                       error_count = 0;
  int                       quiet_cycles = 0;

  array_priority_queue_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .entry_value    (entry_value),
    .entry_priority (entry_priority),
    .done           (done),
    .status         (status),
    .taken_value    (taken_value),
    .taken_priority (taken_priority),
    .head_valid     (head_valid),
    .head_value     (head_value),
    .head_priority  (head_priority),
    .entry_count    (entry_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Position of the entry the next dequeue takes: highest priority, then larger value,
  // then the earliest position.
  function automatic int best_slot();
    int pick;
    int i;
    pick = 0;
    for (i = 1; i < shadow_len; i++) begin
      if (shadow_prio[i] > shadow_prio[pick] ||
          (shadow_prio[i] == shadow_prio[pick] && shadow_value[i] > shadow_value[pick]))
        pick = i;
    end
    return pick;
  endfunction

  // Applies one command to the shadow queue and returns the word it should produce.
  function automatic result_word_t apply_command(input op_t op,
                                                 input logic signed [VAL_W-1:0] value,
                                                 input logic signed [PRI_W-1:0] prio);
    result_word_t w;
    int k;
    int i;
    w = '0;
    w.status = STATUS_DONE;
    if (op == OP_ENQUEUE) begin
      if (shadow_len >= QUEUE_DEPTH) begin
        w.status = STATUS_FULL;
      end else begin
        shadow_value[shadow_len] = value;
        shadow_prio[shadow_len]  = prio;
        shadow_len++;
      end
    end else if (shadow_len == 0) begin
      w.status = STATUS_EMPTY;
    end else begin
      k = best_slot();
      w.taken_value    = shadow_value[k];
      w.taken_priority = shadow_prio[k];
      // Close the gap so that arrival order is kept.
      for (i = k; i + 1 < shadow_len; i++) begin
        shadow_value[i] = shadow_value[i + 1];
        shadow_prio[i]  = shadow_prio[i + 1];
      end
      shadow_len--;
    end
    if (shadow_len > 0) begin
      k = best_slot();
      w.head_valid    = 1'b1;
      w.head_value    = shadow_value[k];
      w.head_priority = shadow_prio[k];
    end
    w.entry_count = CNT_W'(shadow_len);
    return w;
  endfunction

  function automatic result_word_t word(input status_t st,
                                        input logic signed [VAL_W-1:0] tv,
                                        input logic signed [PRI_W-1:0] tp,
                                        input logic hv,
                                        input logic signed [VAL_W-1:0] hval,
                                        input logic signed [PRI_W-1:0] hp,
                                        input int cnt);
    result_word_t w;
    w.status         = st;
    w.taken_value    = tv;
    w.taken_priority = tp;
    w.head_valid     = hv;
    w.head_value     = hval;
    w.head_priority  = hp;
    w.entry_count    = CNT_W'(cnt);
    return w;
  endfunction

  task automatic add_row(input op_t op, input logic signed [VAL_W-1:0] value,
                         input logic signed [PRI_W-1:0] prio, input bit typed,
                         input result_word_t w);
    plan_row_t row;
    row.op    = op;
    row.value = value;
    row.prio  = prio;
    row.typed = typed;
    row.word  = w;
    plan.push_back(row);
  endtask

  // Random field values lean towards the extremes and towards small sets that force ties.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 4))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return int'($urandom_range(0, 6)) - 3;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [PRI_W-1:0] pick_prio();
    case ($urandom_range(0, 4))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return PRI_W'(int'($urandom_range(0, 4)) - 2);
      default: return PRI_W'($urandom());
    endcase
  endfunction

  // Offers one command word and holds it until the block takes it.
  task automatic issue(input op_t op, input logic signed [VAL_W-1:0] value,
                       input logic signed [PRI_W-1:0] prio, input bit typed,
                       input result_word_t w);
    result_word_t predicted;
    start          <= 1'b1;
    operation      <= op;
    entry_value    <= value;
    entry_priority <= prio;
    do @(posedge clk); while (busy);
    predicted = apply_command(op, value, prio);
    words_due.push_back(typed ? w : predicted);
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Holds the sender off until every outstanding result word has arrived.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (words_due.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      error_count++;
    end
  endtask

  // Compare every result word with the oldest one outstanding.
  always @(posedge clk) begin : check_results
    result_word_t want;
    if (!rst && done) begin
      if (words_due.size() == 0) begin
        $error("result word with none outstanding");
        error_count++;
      end else begin
        want = words_due.pop_front();
        check_field("status", VAL_W'(want.status), VAL_W'(status));
        check_field("taken_value", want.taken_value, taken_value);
        check_field("taken_priority", VAL_W'(want.taken_priority), VAL_W'(taken_priority));
        check_field("head_valid", VAL_W'(want.head_valid), VAL_W'(head_valid));
        check_field("head_value", want.head_value, head_value);
        check_field("head_priority", VAL_W'(want.head_priority), VAL_W'(head_priority));
        check_field("entry_count", VAL_W'(want.entry_count), VAL_W'(entry_count));
      end
    end
  end

  // The run ends if neither a command nor a result word moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int n;
    int seg_left;
    int enq_pct;
    int idle_pct;
    op_t op;

    // Directed table: empty queue, lowest priority, ties on priority and on value,
    // extremes and alternating bit patterns.
    add_row(OP_DEQUEUE, '0, '0, 1'b1, word(STATUS_EMPTY, '0, '0, 1'b0, '0, '0, 0));
    add_row(OP_ENQUEUE, 32'h7FFF_FFFF, 16'h8000, 1'b1,
            word(STATUS_DONE, '0, '0, 1'b1, 32'h7FFF_FFFF, 16'h8000, 1));
    add_row(OP_DEQUEUE, '0, '0, 1'b1,
            word(STATUS_DONE, 32'h7FFF_FFFF, 16'h8000, 1'b0, '0, '0, 0));
    add_row(OP_DEQUEUE, '0, '0, 1'b1, word(STATUS_EMPTY, '0, '0, 1'b0, '0, '0, 0));
    add_row(OP_ENQUEUE, 32'h8000_0000, 16'h7FFF, 1'b1,
            word(STATUS_DONE, '0, '0, 1'b1, 32'h8000_0000, 16'h7FFF, 1));
    add_row(OP_ENQUEUE, 32'sd5, 16'h7FFF, 1'b0, '0);
    add_row(OP_ENQUEUE, 32'sd5, 16'h7FFF, 1'b0, '0);
    add_row(OP_ENQUEUE, -32'sd1, 16'h8000, 1'b0, '0);
    add_row(OP_ENQUEUE, 32'sd0, 16'h0000, 1'b0, '0);
    add_row(OP_ENQUEUE, 32'h5555_5555, 16'h5555, 1'b0, '0);
    add_row(OP_ENQUEUE, 32'hAAAA_AAAA, 16'hAAAA, 1'b0, '0);
    repeat (7) add_row(OP_DEQUEUE, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, '0);
    add_row(OP_DEQUEUE, '0, '0, 1'b1, word(STATUS_EMPTY, '0, '0, 1'b0, '0, '0, 0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if ($urandom_range(0, 3) == 0) pause($urandom_range(1, 6));
      issue(plan[i].op, plan[i].value, plan[i].prio, plan[i].typed, plan[i].word);
    end
    settle();

    // Random part in segments: a fill past full, a drain past empty, then mixed
    // segments with varying bias and idling.
    seg_left = 0;
    enq_pct  = 50;
    idle_pct = 0;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 0) begin
        seg_left = QUEUE_DEPTH + 7;
        enq_pct  = 100;
        idle_pct = 20;
      end else if (seg_left == 0) begin
        if (n == QUEUE_DEPTH + 7) begin
          seg_left = QUEUE_DEPTH + 7;
          enq_pct  = 0;
        end else begin
          seg_left = $urandom_range(20, 60);
          case ($urandom_range(0, 2))
            0:       enq_pct = 85;
            1:       enq_pct = 15;
            default: enq_pct = 50;
          endcase
          if (n < RANDOM_WORDS - CALM_WORDS && $urandom_range(0, 2) == 0) settle();
        end
        idle_pct = ($urandom_range(0, 1) == 0) ? 0 : 30;
      end
      seg_left--;
      if (n < RANDOM_WORDS - CALM_WORDS && $urandom_range(1, 100) <= idle_pct)
        pause($urandom_range(1, 6));
      op = ($urandom_range(1, 100) <= enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
      issue(op, pick_value(), pick_prio(), 1'b0, '0);
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/apq_pkg.sv
sv/apq_ram.sv
sv/apq_best.sv
sv/array_priority_queue_unit.sv
dv/tb_top.sv
